// ----- rtl/rqts_pkg.sv -----
// Shared types, codes and sizes for the ready queue thread scheduler.
package rqts_pkg;

  localparam int READY_DEPTH = 16;
  localparam int ADDR_W      = $clog2(READY_DEPTH);
  localparam int CNT_W       = $clog2(READY_DEPTH + 1);
  localparam int RC_W        = 5;

  localparam logic [2:0] REQ_ADD      = 3'd0;
  localparam logic [2:0] REQ_DISPATCH = 3'd1;
  localparam logic [2:0] REQ_LEAVE    = 3'd2;
  localparam logic [2:0] REQ_BACK     = 3'd3;
  localparam logic [2:0] REQ_TICK     = 3'd4;

  localparam logic [2:0] ST_ACCEPT   = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_PREEMPT  = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  localparam logic [1:0] MODE_FIFO    = 2'd0;
  localparam logic [1:0] MODE_PRIO    = 2'd1;
  localparam logic [1:0] MODE_QUANTUM = 2'd2;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [15:0] QUANTUM_RESET = 16'd1000;
  localparam logic [15:0] QUANTUM_SAT   = 16'hFFFF;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] thread_id;
    logic [7:0] process_id;
    logic [7:0] prio_level;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [7:0]      out_thread;
    logic [7:0]      out_process;
    logic [RC_W-1:0] ready_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0] thread_id;
    logic [7:0] process_id;
    logic [7:0] prio_level;
  } entry_t;

endpackage

// ----- rtl/ready_queue_thread_scheduler.sv -----
// Ready queue thread scheduler: ready list in a one-port-write memory, one running slot.
// Add, leave, preempted back, tick and refused dispatches: result in the cycle after accept.
// Dispatch: a scan of the list (one entry read per cycle, FIFO mode reads only the head)
// then a shift-down of the entries behind the chosen one, then the result.
// One word in flight; busy is high during a dispatch.
// Synchronous reset empties the list and the slot; mode 0, quantum 1000. No result stall.
module ready_queue_thread_scheduler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  rqts_pkg::req_t            req,
  output logic                      done,
  output rqts_pkg::rsp_t            rsp,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0] state;

  rqts_pkg::entry_t mem [rqts_pkg::READY_DEPTH];
  rqts_pkg::entry_t rd_data;
  logic                        mem_we;
  logic [rqts_pkg::ADDR_W-1:0] mem_waddr;
  logic [rqts_pkg::ADDR_W-1:0] mem_raddr;
  rqts_pkg::entry_t            mem_wdata;

  logic [rqts_pkg::CNT_W-1:0]  used;
  logic [rqts_pkg::CNT_W-1:0]  rd_ptr;
  logic [rqts_pkg::CNT_W-1:0]  scan_end;
  logic                        pend;
  logic [rqts_pkg::ADDR_W-1:0] pend_addr;
  rqts_pkg::entry_t            best;
  logic [rqts_pkg::ADDR_W-1:0] best_idx;

  logic             run_valid;
  rqts_pkg::entry_t run;
  logic [15:0]      quantum_elapsed;
  logic [15:0]      quantum_next;
  logic             preempt_sent;
  logic [1:0]       sched_mode;
  logic [15:0]      quantum_ticks;

  logic accept;
  logic has_room;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign has_room = (used < rqts_pkg::CNT_W'(rqts_pkg::READY_DEPTH));
  assign quantum_next = (quantum_elapsed == rqts_pkg::QUANTUM_SAT) ?
                        quantum_elapsed : quantum_elapsed + 16'd1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = used[rqts_pkg::ADDR_W-1:0];
    mem_wdata = '{thread_id: req.thread_id, process_id: req.process_id,
                  prio_level: req.prio_level};
    mem_raddr = rd_ptr[rqts_pkg::ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept && has_room) begin
          if (req.req_type == rqts_pkg::REQ_ADD) begin
            mem_we = 1'b1;
          end else if (req.req_type == rqts_pkg::REQ_BACK && run_valid) begin
            mem_we    = 1'b1;
            mem_wdata = run;
          end
        end
      end
      S_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr - 1'b1;
          mem_wdata = rd_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      used            <= '0;
      rd_ptr          <= '0;
      pend            <= 1'b0;
      run_valid       <= 1'b0;
      run             <= '0;
      quantum_elapsed <= '0;
      preempt_sent    <= 1'b0;
      sched_mode      <= rqts_pkg::MODE_FIFO;
      quantum_ticks   <= rqts_pkg::QUANTUM_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rqts_pkg::CFG_MODE:    sched_mode    <= cfg_data[1:0];
          rqts_pkg::CFG_QUANTUM: quantum_ticks <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rsp.out_thread  <= '0;
            rsp.out_process <= '0;
            rsp.ready_count <= rqts_pkg::RC_W'(used);
            rsp.status      <= rqts_pkg::ST_IGNORED;
            done            <= 1'b1;
            case (req.req_type)
              rqts_pkg::REQ_ADD: begin
                if (has_room) begin
                  used            <= rqts_pkg::CNT_W'(used + 1'b1);
                  rsp.ready_count <= rqts_pkg::RC_W'(used + 1'b1);
                  rsp.status      <= rqts_pkg::ST_ACCEPT;
                end else begin
                  rsp.status <= rqts_pkg::ST_FULL;
                end
              end
              rqts_pkg::REQ_DISPATCH: begin
                if (run_valid || sched_mode > rqts_pkg::MODE_QUANTUM) begin
                  rsp.status <= rqts_pkg::ST_IGNORED;
                end else if (used == '0) begin
                  rsp.status <= rqts_pkg::ST_EMPTY;
                end else begin
                  done     <= 1'b0;
                  state    <= S_SCAN;
                  rd_ptr   <= '0;
                  pend     <= 1'b0;
                  scan_end <= (sched_mode == rqts_pkg::MODE_FIFO) ?
                              rqts_pkg::CNT_W'(1) : used;
                end
              end
              rqts_pkg::REQ_LEAVE: begin
                if (run_valid) begin
                  run_valid  <= 1'b0;
                  rsp.status <= rqts_pkg::ST_ACCEPT;
                end
              end
              rqts_pkg::REQ_BACK: begin
                if (run_valid) begin
                  run_valid <= 1'b0;
                  if (has_room) begin
                    used            <= rqts_pkg::CNT_W'(used + 1'b1);
                    rsp.ready_count <= rqts_pkg::RC_W'(used + 1'b1);
                    rsp.status      <= rqts_pkg::ST_ACCEPT;
                  end else begin
                    rsp.status <= rqts_pkg::ST_FULL;
                  end
                end
              end
              rqts_pkg::REQ_TICK: begin
                rsp.status <= rqts_pkg::ST_ACCEPT;
                if (run_valid && !preempt_sent) begin
                  quantum_elapsed <= quantum_next;
                  if (quantum_next >= quantum_ticks) begin
                    preempt_sent    <= 1'b1;
                    rsp.status      <= rqts_pkg::ST_PREEMPT;
                    rsp.out_thread  <= run.thread_id;
                    rsp.out_process <= run.process_id;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (rd_ptr < scan_end) begin
            rd_ptr    <= rqts_pkg::CNT_W'(rd_ptr + 1'b1);
            pend      <= 1'b1;
            pend_addr <= rd_ptr[rqts_pkg::ADDR_W-1:0];
          end else begin
            pend <= 1'b0;
          end
          // strict compare keeps the oldest of equal priorities
          if (pend && (pend_addr == '0 || rd_data.prio_level < best.prio_level)) begin
            best     <= rd_data;
            best_idx <= pend_addr;
          end
          if (rd_ptr == scan_end && !pend) begin
            state  <= S_SHIFT;
            rd_ptr <= rqts_pkg::CNT_W'(best_idx) + 1'b1;
          end
        end
        S_SHIFT: begin
          if (rd_ptr < used) begin
            rd_ptr    <= rqts_pkg::CNT_W'(rd_ptr + 1'b1);
            pend      <= 1'b1;
            pend_addr <= rd_ptr[rqts_pkg::ADDR_W-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (rd_ptr >= used && !pend) begin
            state           <= S_IDLE;
            used            <= rqts_pkg::CNT_W'(used - 1'b1);
            run_valid       <= 1'b1;
            run             <= best;
            quantum_elapsed <= '0;
            preempt_sent    <= (sched_mode != rqts_pkg::MODE_QUANTUM);
            rsp.status      <= rqts_pkg::ST_DISPATCH;
            rsp.out_thread  <= best.thread_id;
            rsp.out_process <= best.process_id;
            rsp.ready_count <= rqts_pkg::RC_W'(used - 1'b1);
            done            <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rqts_checker.sv -----
// Port-level assertions for the ready queue thread scheduler, bound to the top level.
module rqts_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input rqts_pkg::req_t req,
  input logic           done,
  input rqts_pkg::rsp_t rsp,
  input logic           cfg_we,
  input logic           cfg_index,
  input logic [15:0]    cfg_data
);

  // every word other than a dispatch answers in the next cycle
  a_quick_rsp: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.req_type != rqts_pkg::REQ_DISPATCH |=> done)
    else $error("missing single-cycle result");

  a_end_rsp: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done && rsp.status == rqts_pkg::ST_DISPATCH)
    else $error("dispatch finished without result");

  a_ids_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != rqts_pkg::ST_DISPATCH && rsp.status != rqts_pkg::ST_PREEMPT
    |-> rsp.out_thread == '0 && rsp.out_process == '0)
    else $error("ids set on plain result");

  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.ready_count <= rqts_pkg::RC_W'(rqts_pkg::READY_DEPTH))
    else $error("ready count beyond depth");

  a_reset: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("activity after reset");

endmodule

bind ready_queue_thread_scheduler rqts_checker u_rqts_checker (.*);

// ----- tb/sv/tb_ready_queue_thread_scheduler.sv -----
// Testbench for ready_queue_thread_scheduler: directed and random words against a predictor.
`timescale 1ns / 1ps
module tb_ready_queue_thread_scheduler;
  import rqts_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [2:0] REQ_TOP       = 3'd7;
  localparam int         DRAIN_CYCLES  = 2 * READY_DEPTH + 5;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  req_t        req_word  = '0;
  logic        done;
  rsp_t        rsp_word;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;

  // scheduler state as predicted
  entry_t      ready_list[$];
  entry_t      run_slot     = '0;
  logic        run_busy     = 1'b0;
  int unsigned run_ticks    = 0;
  logic        preempt_done = 1'b0;
  logic [1:0]  cur_mode     = MODE_FIFO;
  logic [15:0] cur_quantum  = QUANTUM_RESET;

  rsp_t due_rsp[$];
  int   mismatches  = 0;
  int   words_sent  = 0;
  int   words_seen  = 0;
  int   status_seen[8];
  int   gap_pct     = 0;

  always #5 clk = ~clk;

  ready_queue_thread_scheduler uut (
    .clk, .rst, .start, .busy, .req(req_word), .done, .rsp(rsp_word),
    .cfg_we, .cfg_index, .cfg_data
  );

  function automatic rsp_t next_rsp(input req_t w);
    rsp_t   r;
    entry_t e;
    int     pick;
    int     i;
    r = '0;
    r.status = ST_IGNORED;
    case (w.req_type)
      REQ_ADD: begin
        if (ready_list.size() < READY_DEPTH) begin
          e.thread_id  = w.thread_id;
          e.process_id = w.process_id;
          e.prio_level = w.prio_level;
          ready_list.push_back(e);
          r.status = ST_ACCEPT;
        end else begin
          r.status = ST_FULL;
        end
      end
      REQ_DISPATCH: begin
        if (!run_busy && cur_mode != MODE_RESERVED) begin
          if (ready_list.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pick = 0;
            if (cur_mode != MODE_FIFO) begin
              for (i = 1; i < ready_list.size(); i++)
                if (ready_list[i].prio_level < ready_list[pick].prio_level) pick = i;
            end
            run_slot = ready_list[pick];
            ready_list.delete(pick);
            run_busy     = 1'b1;
            run_ticks    = 0;
            preempt_done = (cur_mode != MODE_QUANTUM);
            r.status      = ST_DISPATCH;
            r.out_thread  = run_slot.thread_id;
            r.out_process = run_slot.process_id;
          end
        end
      end
      REQ_LEAVE: begin
        if (run_busy) begin
          run_busy = 1'b0;
          r.status = ST_ACCEPT;
        end
      end
      REQ_BACK: begin
        if (run_busy) begin
          run_busy = 1'b0;
          if (ready_list.size() < READY_DEPTH) begin
            ready_list.push_back(run_slot);
            r.status = ST_ACCEPT;
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      REQ_TICK: begin
        r.status = ST_ACCEPT;
        if (run_busy && !preempt_done) begin
          if (run_ticks < QUANTUM_SAT) run_ticks++;
          if (run_ticks >= cur_quantum) begin
            preempt_done  = 1'b1;
            r.status      = ST_PREEMPT;
            r.out_thread  = run_slot.thread_id;
            r.out_process = run_slot.process_id;
          end
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.ready_count = RC_W'(ready_list.size());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: word %0d: %s", $time, words_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (due_rsp.size() == 0) begin
        report_mismatch($sformatf("result word with none due, status %0d", rsp_word.status));
      end else begin
        want = due_rsp.pop_front();
        status_seen[want.status]++;
        if (rsp_word.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_word.status, want.status));
        if (rsp_word.out_thread !== want.out_thread)
          report_mismatch($sformatf("out_thread %0d, want %0d",
                                    rsp_word.out_thread, want.out_thread));
        if (rsp_word.out_process !== want.out_process)
          report_mismatch($sformatf("out_process %0d, want %0d",
                                    rsp_word.out_process, want.out_process));
        if (rsp_word.ready_count !== want.ready_count)
          report_mismatch($sformatf("ready_count %0d, want %0d",
                                    rsp_word.ready_count, want.ready_count));
      end
      words_seen++;
    end
  end

  task automatic send_word(input req_t w);
    if (!start) start <= 1'b1;
    req_word <= w;
    do @(posedge clk); while (busy);
    due_rsp.push_back(next_rsp(w));
    words_sent++;
    // idle cycle by cycle with probability gap_pct
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic put(input logic [2:0] kind, input logic [7:0] tid, input logic [7:0] pid,
                     input logic [7:0] prio);
    req_t w;
    w.req_type   = kind;
    w.thread_id  = tid;
    w.process_id = pid;
    w.prio_level = prio;
    send_word(w);
  endtask

  task automatic put_op(input logic [2:0] kind);
    put(kind, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // hold off until every due result is back and the block is idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (due_rsp.size() != 0 || busy);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [15:0] quantum);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {14'($urandom), mode};
    @(posedge clk);
    cfg_index <= CFG_QUANTUM;
    cfg_data  <= quantum;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode    = mode;
    cur_quantum = quantum;
  endtask

  task automatic test_idle_requests();
    logic [2:0] kind;
    put_op(REQ_DISPATCH);
    put_op(REQ_LEAVE);
    put_op(REQ_BACK);
    put_op(REQ_TICK);
    kind = REQ_TICK;
    while (kind != REQ_TOP) begin
      kind++;
      put_op(kind);
    end
  endtask

  task automatic test_fifo_order();
    put(REQ_ADD, 8'h00, 8'hFF, 8'hFF);
    put(REQ_ADD, 8'hFF, 8'h00, 8'h00);
    put_op(REQ_DISPATCH);
    put_op(REQ_DISPATCH);
    put_op(REQ_TICK);
    put_op(REQ_BACK);
    put_op(REQ_LEAVE);
  endtask

  task automatic test_full_list();
    int i;
    i = 0;
    while (ready_list.size() < READY_DEPTH) begin
      put(REQ_ADD, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'(i % 3 + 1));
      i++;
    end
    put_op(REQ_ADD);
    put_op(REQ_DISPATCH);
    put_op(REQ_ADD);
    put_op(REQ_BACK);
  endtask

  task automatic test_priority_pick();
    set_config(MODE_PRIO, QUANTUM_RESET);
    put_op(REQ_DISPATCH);
    put_op(REQ_TICK);
    put_op(REQ_LEAVE);
    put_op(REQ_DISPATCH);
    put_op(REQ_LEAVE);
  endtask

  task automatic test_quantum_expiry();
    set_config(MODE_QUANTUM, 16'd0);
    put_op(REQ_DISPATCH);
    put_op(REQ_TICK);
    put_op(REQ_TICK);
    put_op(REQ_BACK);
    // arming stays with the dispatch when the mode changes under it
    set_config(MODE_QUANTUM, 16'd3);
    put_op(REQ_DISPATCH);
    set_config(MODE_PRIO, 16'd3);
    repeat (3) put_op(REQ_TICK);
    put_op(REQ_LEAVE);
    set_config(MODE_QUANTUM, QUANTUM_SAT);
    put_op(REQ_DISPATCH);
    put_op(REQ_TICK);
    put_op(REQ_LEAVE);
  endtask

  task automatic test_reserved_mode();
    set_config(MODE_RESERVED, 16'd1);
    put_op(REQ_DISPATCH);
    put_op(REQ_TICK);
  endtask

  function automatic req_t random_word(input int fill_bias);
    req_t w;
    int   roll;
    roll = $urandom_range(99);
    if (!run_busy) begin
      if (roll < 40 + fill_bias)  w.req_type = REQ_ADD;
      else if (roll < 85)         w.req_type = REQ_DISPATCH;
      else if (roll < 89)         w.req_type = REQ_LEAVE;
      else if (roll < 93)         w.req_type = REQ_BACK;
      else if (roll < 97)         w.req_type = REQ_TICK;
      else                        w.req_type = 3'($urandom_range(REQ_TICK + 1, REQ_TOP));
    end else begin
      if (roll < 15 + fill_bias)  w.req_type = REQ_ADD;
      else if (roll < 60)         w.req_type = REQ_TICK;
      else if (roll < 75)         w.req_type = REQ_BACK;
      else if (roll < 90)         w.req_type = REQ_LEAVE;
      else if (roll < 95)         w.req_type = REQ_DISPATCH;
      else                        w.req_type = 3'($urandom_range(REQ_TICK + 1, REQ_TOP));
    end
    w.thread_id  = 8'($urandom_range(255));
    w.process_id = 8'($urandom_range(255));
    // narrow priorities half the time so ties occur
    w.prio_level = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    return w;
  endfunction

  task automatic test_random(input int count, input int pct);
    int         sent;
    int         next_cfg;
    int         fill_bias;
    req_t       w;
    logic [1:0] mode;
    logic [15:0] quantum;
    gap_pct   = pct;
    sent      = 0;
    next_cfg  = 0;
    fill_bias = 0;
    while (sent < count) begin
      if (sent >= next_cfg) begin
        mode = ($urandom_range(9) == 0) ? MODE_RESERVED : 2'($urandom_range(2));
        quantum = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
        set_config(mode, quantum);
        fill_bias = ($urandom_range(3) == 0) ? 40 : 0;
        next_cfg += 40;
      end
      w = random_word(fill_bias);
      send_word(w);
      if (w.req_type <= REQ_TICK) sent++;
      if ($urandom_range(99) == 0) settle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 31;
    test_idle_requests();
    test_fifo_order();
    test_full_list();
    test_priority_pick();
    test_quantum_expiry();
    test_reserved_mode();
    test_random(170, 31);
    test_random(170, 85);
    test_random(160, 0);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d request words, %0d results: %0d dispatched, %0d preempt requests",
             words_sent, words_seen, status_seen[ST_DISPATCH], status_seen[ST_PREEMPT]);
    $display("%0d list-full drops, %0d empty dispatches, %0d ignored; %0d mismatches",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_IGNORED], mismatches);
    if (mismatches == 0) begin
      $display("tb_ready_queue_thread_scheduler passed");
    end else begin
      $display("tb_ready_queue_thread_scheduler failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still due", due_rsp.size());
    $display("tb_ready_queue_thread_scheduler failed");
    $finish;
  end

endmodule
